>>> hdl/tsp_pkg.sv
package tsp_pkg;

    // Transport packet geometry
    localparam int PACKET_BYTES = 188;
    localparam int HEADER_BYTES = 4;
    localparam logic [7:0] PKT_END_POS = 8'(PACKET_BYTES);
    localparam logic [7:0] HDR_END_POS = 8'(HEADER_BYTES);

    localparam logic [7:0] SYNC_MARK    = 8'h47;
    localparam logic [7:0] POINTER_BYTE = 8'h00;
    localparam logic [7:0] PAD_BYTE     = 8'hff;

    // APB register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_ERROR    = 3'd0,
        REG_PRIORITY = 3'd1,
        REG_SCRAMBLE = 3'd2,
        REG_ADAPT    = 3'd3,
        REG_START_CC = 3'd4
    } t_reg_idx;

    // Header fields taken from configuration
    typedef struct packed {
        logic       error_ind;
        logic       prio_bit;
        logic [1:0] scrambling;
        logic [1:0] adaptation;
    } t_cfg;

    // Source of the byte appended to the packet
    typedef enum logic [1:0] {
        SEL_INPUT   = 2'd0,
        SEL_HELD    = 2'd1,
        SEL_POINTER = 2'd2,
        SEL_PAD     = 2'd3
    } t_byte_sel;

    // Controller to datapath
    typedef struct packed {
        logic      accept;
        logic      put;
        t_byte_sel sel;
        logic      header;
        logic      closing;
        logic      end_section;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pos_zero;
        logic pkt_full_next;
        logic slot_free;
        logic first;
        logic held_last;
    } t_stat;

endpackage

>>> hdl/tsp_cfg.sv
module tsp_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tsp_pkg::ADDR_W-1:0] paddr,
    input  logic [tsp_pkg::DATA_W-1:0] pwdata,
    output logic [tsp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output tsp_pkg::t_cfg              o_cfg,
    output logic                       o_cc_load,
    output logic [3:0]                 o_cc_value
);
    import tsp_pkg::*;

    t_cfg       r_cfg;
    logic [3:0] r_start_cc;
    logic       wr_en;
    t_reg_idx   idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.error_ind  <= 1'b0;
            r_cfg.prio_bit   <= 1'b0;
            r_cfg.scrambling <= 2'd0;
            r_cfg.adaptation <= 2'd1;
            r_start_cc       <= 4'd0;
        end else if (wr_en) begin
            unique case (idx)
                REG_ERROR:    r_cfg.error_ind  <= pwdata[0];
                REG_PRIORITY: r_cfg.prio_bit   <= pwdata[0];
                REG_SCRAMBLE: r_cfg.scrambling <= pwdata[1:0];
                REG_ADAPT:    r_cfg.adaptation <= pwdata[1:0];
                REG_START_CC: r_start_cc       <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_ERROR:    prdata = DATA_W'(r_cfg.error_ind);
            REG_PRIORITY: prdata = DATA_W'(r_cfg.prio_bit);
            REG_SCRAMBLE: prdata = DATA_W'(r_cfg.scrambling);
            REG_ADAPT:    prdata = DATA_W'(r_cfg.adaptation);
            REG_START_CC: prdata = DATA_W'(r_start_cc);
            default:      prdata = '0;
        endcase
    end

    // Writing the start value also reloads the continuity counter
    assign o_cfg      = r_cfg;
    assign o_cc_load  = wr_en && (idx == REG_START_CC);
    assign o_cc_value = pwdata[3:0];

endmodule

>>> hdl/tsp_ctrl.sv
module tsp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_s_tlast,
    output logic           o_s_tready,
    input  tsp_pkg::t_stat i_stat,
    output tsp_pkg::t_cmd  o_cmd
);
    import tsp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HDR  = 5'b00010,
        S_PTR  = 5'b00100,
        S_DATA = 5'b01000,
        S_PAD  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   acc;

    assign o_s_tready = (r_state == S_IDLE) && i_stat.slot_free;
    assign acc        = o_s_tready && i_s_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Sequencing: header, pointer byte, data byte, padding
    always_comb begin
        n_state           = r_state;
        o_cmd.accept      = 1'b0;
        o_cmd.put         = 1'b0;
        o_cmd.sel         = SEL_INPUT;
        o_cmd.header      = 1'b0;
        o_cmd.closing     = 1'b0;
        o_cmd.end_section = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = acc;
                if (acc) begin
                    if (i_stat.pos_zero) begin
                        n_state = S_HDR;
                    end else begin
                        // mid-packet byte goes straight in
                        o_cmd.put         = 1'b1;
                        o_cmd.sel         = SEL_INPUT;
                        o_cmd.closing     = i_s_tlast;
                        o_cmd.end_section = i_s_tlast;
                        if (i_s_tlast && !i_stat.pkt_full_next) n_state = S_PAD;
                    end
                end
            end
            S_HDR: begin
                if (i_stat.slot_free) begin
                    o_cmd.header = 1'b1;
                    n_state      = i_stat.first ? S_PTR : S_DATA;
                end
            end
            S_PTR: begin
                // pointer byte never completes a word
                o_cmd.put = 1'b1;
                o_cmd.sel = SEL_POINTER;
                n_state   = S_DATA;
            end
            S_DATA: begin
                if (i_stat.slot_free) begin
                    o_cmd.put         = 1'b1;
                    o_cmd.sel         = SEL_HELD;
                    o_cmd.closing     = i_stat.held_last;
                    o_cmd.end_section = i_stat.held_last;
                    if (i_stat.held_last && !i_stat.pkt_full_next) n_state = S_PAD;
                    else                                           n_state = S_IDLE;
                end
            end
            S_PAD: begin
                if (i_stat.slot_free) begin
                    o_cmd.put     = 1'b1;
                    o_cmd.sel     = SEL_PAD;
                    o_cmd.closing = 1'b1;
                    if (i_stat.pkt_full_next) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> hdl/tsp_dpath.sv
module tsp_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tsp_pkg::t_cmd i_cmd,
    input  tsp_pkg::t_cfg i_cfg,
    input  logic          i_cc_load,
    input  logic [3:0]    i_cc_value,
    input  logic [7:0]    i_s_tdata,
    input  logic          i_s_tlast,
    input  logic [12:0]   i_s_tuser,
    input  logic          i_m_tready,
    output tsp_pkg::t_stat o_stat,
    output logic          o_m_tvalid,
    output logic [31:0]   o_m_tdata,
    output logic          o_m_tlast,
    output logic [0:0]    o_m_tuser
);
    import tsp_pkg::*;

    logic [7:0]  r_pos;
    logic [23:0] r_asm;
    logic [3:0]  r_cc;
    logic        r_in_sec;
    logic [12:0] r_pid;
    logic        r_first;
    logic [7:0]  r_byte;
    logic        r_last;
    logic        r_ovalid;
    logic [31:0] r_oword;
    logic        r_opend;
    logic        r_osend;

    logic [7:0]  put_byte;
    logic [7:0]  pos_inc;
    logic        word_done;
    logic        pend;
    logic        slot_free;
    logic        load;
    logic [31:0] hdr_word;

    assign pos_inc   = r_pos + 8'd1;
    assign word_done = (pos_inc[1:0] == 2'd0);
    assign pend      = (pos_inc == PKT_END_POS);
    assign slot_free = !r_ovalid || i_m_tready;
    assign load      = i_cmd.header || (i_cmd.put && word_done);

    // Byte source
    always_comb begin
        case (i_cmd.sel)
            SEL_INPUT:   put_byte = i_s_tdata;
            SEL_HELD:    put_byte = r_byte;
            SEL_POINTER: put_byte = POINTER_BYTE;
            SEL_PAD:     put_byte = PAD_BYTE;
            default:     put_byte = PAD_BYTE;
        endcase
    end

    assign hdr_word = {SYNC_MARK,
                       i_cfg.error_ind, r_first, i_cfg.prio_bit, r_pid[12:8],
                       r_pid[7:0],
                       i_cfg.scrambling, i_cfg.adaptation, r_cc};

    // Section state and held item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sec <= 1'b0;
        end else if (i_cmd.end_section) begin
            r_in_sec <= 1'b0;
        end else if (i_cmd.accept) begin
            r_in_sec <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte  <= i_s_tdata;
            r_last  <= i_s_tlast;
            r_first <= !r_in_sec;
            if (!r_in_sec) r_pid <= i_s_tuser;
        end
    end

    // Packet position and word assembly
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_asm <= '0;
        end else if (i_cmd.header) begin
            r_pos <= HDR_END_POS;
            r_asm <= '0;
        end else if (i_cmd.put) begin
            if (word_done) begin
                r_pos <= pend ? 8'd0 : pos_inc;
                r_asm <= '0;
            end else begin
                r_pos <= pos_inc;
                r_asm <= {r_asm[15:0], put_byte};
            end
        end
    end

    // Continuity counter, advanced per header when adaptation code is odd
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc <= 4'd0;
        end else if (i_cc_load) begin
            r_cc <= i_cc_value;
        end else if (i_cmd.header && i_cfg.adaptation[0]) begin
            r_cc <= r_cc + 4'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (i_cmd.header) begin
                r_oword <= hdr_word;
                r_opend <= 1'b0;
                r_osend <= 1'b0;
            end else begin
                r_oword <= {r_asm, put_byte};
                r_opend <= pend;
                r_osend <= pend && i_cmd.closing;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_oword;
    assign o_m_tlast  = r_opend;
    assign o_m_tuser  = r_osend;

    assign o_stat.pos_zero      = (r_pos == 8'd0);
    assign o_stat.pkt_full_next = pend;
    assign o_stat.slot_free     = slot_free;
    assign o_stat.first         = r_first;
    assign o_stat.held_last     = r_last;

endmodule

>>> hdl/ts_section_packetizer.sv
// Channel   Dir  Handshake                Payload
// s_        in   i_s_tvalid/o_s_tready    tdata[7:0] byte, tlast last, tuser[12:0] pid
// m_        out  o_m_tvalid/i_m_tready    tdata[31:0] word, tlast packet end, tuser section end
// apb       in   psel/penable/pready      5 registers at byte address 4*i
//
// A byte inside an open packet is accepted and put in the same cycle while the
// output is free. A packet's first byte is accepted, the header word loaded, on
// a section's first packet the pointer byte put, then the byte, in order in the
// single byte lane of the sequencer. After a section's last byte, padding runs
// one byte a cycle while the output is free, to the end of the packet, with no
// item accepted. Reset is synchronous; a stall holds all but the pointer step.
module ts_section_packetizer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [7:0]                 i_s_tdata,  // [7:0] section_byte
    input  logic                       i_s_tlast,
    input  logic [12:0]                i_s_tuser,  // [12:0] pid
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [31:0]                o_m_tdata,  // [31:0] out_word
    output logic                       o_m_tlast,
    output logic [0:0]                 o_m_tuser,  // [0] section_end
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tsp_pkg::ADDR_W-1:0] paddr,
    input  logic [tsp_pkg::DATA_W-1:0] pwdata,
    output logic [tsp_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import tsp_pkg::*;

    t_cfg       cfg;
    logic       cc_load;
    logic [3:0] cc_value;
    t_cmd       cmd;
    t_stat      stat;

    tsp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_cfg      (cfg),
        .o_cc_load  (cc_load),
        .o_cc_value (cc_value)
    );

    tsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tsp_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg      (cfg),
        .i_cc_load  (cc_load),
        .i_cc_value (cc_value),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

>>> hdl/tsp_checker.sv
module tsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic [0:0]  o_m_tuser,
    input logic        pready
);
    import tsp_pkg::*;

    // Section end only ever closes a packet
    a_send_on_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast)
        else $error("section end without packet end");

    // No input taken while a finished word is stuck at the output
    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready && o_m_tvalid |-> i_m_tready)
        else $error("input ready while output stalled");

    // A packet's last word is followed by a header word starting with sync
    a_sync_after_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tlast ##1 o_m_tvalid |->
            o_m_tdata[31:24] == SYNC_MARK)
        else $error("packet does not start with sync byte");

    // Stalled word holds
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("output changed while stalled");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind ts_section_packetizer tsp_checker u_tsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser),
    .pready     (pready)
);
